// ===== design/sab_pkg.sv =====
// Shared constants and helpers for the straight-alpha over blend core.
package sab_pkg;

  // Alpha is Q1.12: 4096 means fully opaque, the field is 13 bits wide.
  localparam int ALPHA_BITS = 13;
  localparam int FRAC_BITS  = 12;
  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE = 13'd4096;

  // The combined alpha in Q1.24 never exceeds 2^24, so 25 bits hold it.
  localparam int DEN_BITS = 25;

  // Number of color channels carried side by side.
  localparam int NUM_CH = 3;

  // An alpha code above one counts as fully opaque.
  function automatic logic [ALPHA_BITS-1:0] clamp_alpha(input logic [ALPHA_BITS-1:0] v);
    logic [ALPHA_BITS-1:0] r;
    r = (v > ALPHA_ONE) ? ALPHA_ONE : v;
    return r;
  endfunction

endpackage

// ===== design/sab_mul_stage.sv =====
// First pipeline stage: alpha clamping and the products of alphas and colors.
module sab_mul_stage #(
  parameter int COLOR_BITS = 16
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              valid_i,
  output logic                                              ready_o,
  input  logic [sab_pkg::NUM_CH-1:0][COLOR_BITS-1:0]        base_c_i,
  input  logic [sab_pkg::NUM_CH-1:0][COLOR_BITS-1:0]        mask_c_i,
  input  logic [sab_pkg::ALPHA_BITS-1:0]                    base_alpha_i,
  input  logic [sab_pkg::ALPHA_BITS-1:0]                    mask_alpha_i,
  output logic                                              valid_o,
  input  logic                                              ready_i,
  output logic [sab_pkg::ALPHA_BITS-1:0]                    a_o,
  output logic [sab_pkg::ALPHA_BITS-1:0]                    ma_o,
  output logic [sab_pkg::DEN_BITS-1:0]                      ama_o,
  output logic [sab_pkg::DEN_BITS-1:0]                      w_o,
  output logic [sab_pkg::NUM_CH-1:0][COLOR_BITS+sab_pkg::FRAC_BITS-1:0] mcma_o,
  output logic [sab_pkg::NUM_CH-1:0][COLOR_BITS-1:0]        c_o
);

  localparam int AW = sab_pkg::ALPHA_BITS;
  localparam int DW = sab_pkg::DEN_BITS;
  localparam int PW = COLOR_BITS + sab_pkg::FRAC_BITS;

  logic                                 valid_q;
  logic                                 load;
  logic [AW-1:0]                        a_c;
  logic [AW-1:0]                        ma_c;
  logic [AW-1:0]                        inv_ma;
  logic [AW-1:0]                        a_q;
  logic [AW-1:0]                        ma_q;
  logic [DW-1:0]                        ama_d, ama_q;
  logic [DW-1:0]                        w_d, w_q;
  logic [sab_pkg::NUM_CH-1:0][PW-1:0]   mcma_d, mcma_q;
  logic [sab_pkg::NUM_CH-1:0][COLOR_BITS-1:0] c_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  always_comb begin
    a_c    = sab_pkg::clamp_alpha(base_alpha_i);
    ma_c   = sab_pkg::clamp_alpha(mask_alpha_i);
    inv_ma = sab_pkg::ALPHA_ONE - ma_c;
    ama_d  = DW'(a_c) * DW'(ma_c);
    w_d    = DW'(a_c) * DW'(inv_ma);
    for (int ch = 0; ch < sab_pkg::NUM_CH; ch++) begin
      mcma_d[ch] = PW'(mask_c_i[ch]) * PW'(ma_c);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      a_q    <= a_c;
      ma_q   <= ma_c;
      ama_q  <= ama_d;
      w_q    <= w_d;
      mcma_q <= mcma_d;
      c_q    <= base_c_i;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign ma_o    = ma_q;
  assign ama_o   = ama_q;
  assign w_o     = w_q;
  assign mcma_o  = mcma_q;
  assign c_o     = c_q;

endmodule

// ===== design/sab_sum_stage.sv =====
// Second pipeline stage: the combined alpha and the weighted color numerators.
module sab_sum_stage #(
  parameter int COLOR_BITS = 16
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              valid_i,
  output logic                                              ready_o,
  input  logic [sab_pkg::ALPHA_BITS-1:0]                    a_i,
  input  logic [sab_pkg::ALPHA_BITS-1:0]                    ma_i,
  input  logic [sab_pkg::DEN_BITS-1:0]                      ama_i,
  input  logic [sab_pkg::DEN_BITS-1:0]                      w_i,
  input  logic [sab_pkg::NUM_CH-1:0][COLOR_BITS+sab_pkg::FRAC_BITS-1:0] mcma_i,
  input  logic [sab_pkg::NUM_CH-1:0][COLOR_BITS-1:0]        c_i,
  output logic                                              valid_o,
  input  logic                                              ready_i,
  output logic [sab_pkg::NUM_CH-1:0][COLOR_BITS+sab_pkg::DEN_BITS-2:0] num_o,
  output logic [sab_pkg::DEN_BITS-1:0]                      den_o,
  output logic [sab_pkg::ALPHA_BITS-1:0]                    alpha_o,
  output logic                                              zero_o
);

  localparam int DW = sab_pkg::DEN_BITS;
  localparam int NW = COLOR_BITS + sab_pkg::DEN_BITS - 1;
  localparam int CW = COLOR_BITS + sab_pkg::DEN_BITS;
  localparam int FB = sab_pkg::FRAC_BITS;

  logic                                 valid_q;
  logic                                 load;
  logic [DW-1:0]                        den_d, den_q;
  logic [sab_pkg::NUM_CH-1:0][CW-1:0]   cw;
  logic [sab_pkg::NUM_CH-1:0][NW-1:0]   num_d, num_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // The sum of alphas shifted up can reach 2^25, but the difference always
  // fits, so the wrap of the 25-bit subtraction is harmless.
  always_comb begin
    den_d = ((DW'(a_i) + DW'(ma_i)) << FB) - ama_i;
    for (int ch = 0; ch < sab_pkg::NUM_CH; ch++) begin
      cw[ch]    = CW'(c_i[ch]) * CW'(w_i);
      num_d[ch] = (NW'(mcma_i[ch]) << FB) + NW'(cw[ch]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      den_q <= den_d;
      num_q <= num_d;
    end
  end

  assign valid_o = valid_q;
  assign num_o   = num_q;
  assign den_o   = den_q;
  assign alpha_o = den_q[DW-1:FB];
  assign zero_o  = (den_q == '0);

endmodule

// ===== design/sab_div_cell.sv =====
// One cell of the restoring divider chain: settles one quotient bit per channel.
module sab_div_cell #(
  parameter int COLOR_BITS = 16,
  parameter int BIT        = 0
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              valid_i,
  output logic                                              ready_o,
  input  logic [sab_pkg::NUM_CH-1:0][COLOR_BITS+sab_pkg::DEN_BITS-2:0] rem_i,
  input  logic [sab_pkg::NUM_CH-1:0][COLOR_BITS-1:0]        quo_i,
  input  logic [sab_pkg::DEN_BITS-1:0]                      den_i,
  input  logic [sab_pkg::ALPHA_BITS-1:0]                    alpha_i,
  input  logic                                              zero_i,
  output logic                                              valid_o,
  input  logic                                              ready_i,
  output logic [sab_pkg::NUM_CH-1:0][COLOR_BITS+sab_pkg::DEN_BITS-2:0] rem_o,
  output logic [sab_pkg::NUM_CH-1:0][COLOR_BITS-1:0]        quo_o,
  output logic [sab_pkg::DEN_BITS-1:0]                      den_o,
  output logic [sab_pkg::ALPHA_BITS-1:0]                    alpha_o,
  output logic                                              zero_o
);

  localparam int NW = COLOR_BITS + sab_pkg::DEN_BITS - 1;

  logic                                         valid_q;
  logic                                         load;
  logic [NW-1:0]                                dvs;
  logic [sab_pkg::NUM_CH-1:0]                   ge;
  logic [sab_pkg::NUM_CH-1:0][NW-1:0]           rem_d, rem_q;
  logic [sab_pkg::NUM_CH-1:0][COLOR_BITS-1:0]   quo_d, quo_q;
  logic [sab_pkg::DEN_BITS-1:0]                 den_q;
  logic [sab_pkg::ALPHA_BITS-1:0]               alpha_q;
  logic                                         zero_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // The divisor is aligned with the quotient bit this cell decides.
  always_comb begin
    dvs = NW'(den_i) << BIT;
    for (int ch = 0; ch < sab_pkg::NUM_CH; ch++) begin
      ge[ch]         = (rem_i[ch] >= dvs);
      rem_d[ch]      = ge[ch] ? (rem_i[ch] - dvs) : rem_i[ch];
      quo_d[ch]      = quo_i[ch];
      quo_d[ch][BIT] = ge[ch];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      den_q   <= den_i;
      alpha_q <= alpha_i;
      zero_q  <= zero_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign den_o   = den_q;
  assign alpha_o = alpha_q;
  assign zero_o  = zero_q;

endmodule

// ===== design/straight_alpha_over_blend_core.sv =====
// Top level of the straight-alpha over blend core.
// Composites a mask color over a base color with straight alpha and takes one
// item per clock with no gaps while out_ready_i holds high. In order, one
// stage forms the alpha and color products, one forms the combined alpha and
// the numerators, a chain of COLOR_BITS divider cells settles one quotient bit
// each for all three channels, and an output register holds the result. Every
// stage registers its item and passes it on when the stage after it has room,
// so a bubble anywhere lets a new item in while a result waits. When both
// alphas are zero the colors and alpha come out as zero with both_transparent
// set.
module straight_alpha_over_blend_core #(
  parameter int COLOR_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [COLOR_BITS-1:0]         base_red_i,
  input  logic [COLOR_BITS-1:0]         base_green_i,
  input  logic [COLOR_BITS-1:0]         base_blue_i,
  input  logic [sab_pkg::ALPHA_BITS-1:0] base_alpha_i,
  input  logic [COLOR_BITS-1:0]         mask_red_i,
  input  logic [COLOR_BITS-1:0]         mask_green_i,
  input  logic [COLOR_BITS-1:0]         mask_blue_i,
  input  logic [sab_pkg::ALPHA_BITS-1:0] mask_alpha_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [COLOR_BITS-1:0]         out_red_o,
  output logic [COLOR_BITS-1:0]         out_green_o,
  output logic [COLOR_BITS-1:0]         out_blue_o,
  output logic [sab_pkg::ALPHA_BITS-1:0] out_alpha_o,
  output logic                          both_transparent_o
);

  localparam int NCH = sab_pkg::NUM_CH;
  localparam int AW  = sab_pkg::ALPHA_BITS;
  localparam int DW  = sab_pkg::DEN_BITS;
  localparam int NW  = COLOR_BITS + sab_pkg::DEN_BITS - 1;
  localparam int PW  = COLOR_BITS + sab_pkg::FRAC_BITS;

  logic [NCH-1:0][COLOR_BITS-1:0] base_c;
  logic [NCH-1:0][COLOR_BITS-1:0] mask_c;

  // Product stage to sum stage.
  logic                           m_valid, m_ready;
  logic [AW-1:0]                  m_a, m_ma;
  logic [DW-1:0]                  m_ama, m_w;
  logic [NCH-1:0][PW-1:0]         m_mcma;
  logic [NCH-1:0][COLOR_BITS-1:0] m_c;

  // Divider chain links; link 0 is fed by the sum stage.
  logic [COLOR_BITS:0]                          d_valid, d_ready;
  logic [COLOR_BITS:0][NCH-1:0][NW-1:0]         d_rem;
  logic [COLOR_BITS:0][NCH-1:0][COLOR_BITS-1:0] d_quo;
  logic [COLOR_BITS:0][DW-1:0]                  d_den;
  logic [COLOR_BITS:0][AW-1:0]                  d_alpha;
  logic [COLOR_BITS:0]                          d_zero;

  // Output register.
  logic                           out_valid_q;
  logic                           out_load;
  logic [NCH-1:0][COLOR_BITS-1:0] color_q;
  logic [AW-1:0]                  alpha_q;
  logic                           zero_q;

  assign base_c = {base_blue_i, base_green_i, base_red_i};
  assign mask_c = {mask_blue_i, mask_green_i, mask_red_i};

  sab_mul_stage #(
    .COLOR_BITS(COLOR_BITS)
  ) u_mul (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .base_c_i    (base_c),
    .mask_c_i    (mask_c),
    .base_alpha_i(base_alpha_i),
    .mask_alpha_i(mask_alpha_i),
    .valid_o     (m_valid),
    .ready_i     (m_ready),
    .a_o         (m_a),
    .ma_o        (m_ma),
    .ama_o       (m_ama),
    .w_o         (m_w),
    .mcma_o      (m_mcma),
    .c_o         (m_c)
  );

  sab_sum_stage #(
    .COLOR_BITS(COLOR_BITS)
  ) u_sum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(m_valid),
    .ready_o(m_ready),
    .a_i    (m_a),
    .ma_i   (m_ma),
    .ama_i  (m_ama),
    .w_i    (m_w),
    .mcma_i (m_mcma),
    .c_i    (m_c),
    .valid_o(d_valid[0]),
    .ready_i(d_ready[0]),
    .num_o  (d_rem[0]),
    .den_o  (d_den[0]),
    .alpha_o(d_alpha[0]),
    .zero_o (d_zero[0])
  );

  assign d_quo[0] = '0;

  // Cell k decides quotient bit COLOR_BITS-1-k, most significant first.
  for (genvar k = 0; k < COLOR_BITS; k++) begin : g_div
    sab_div_cell #(
      .COLOR_BITS(COLOR_BITS),
      .BIT       (COLOR_BITS - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .valid_i(d_valid[k]),
      .ready_o(d_ready[k]),
      .rem_i  (d_rem[k]),
      .quo_i  (d_quo[k]),
      .den_i  (d_den[k]),
      .alpha_i(d_alpha[k]),
      .zero_i (d_zero[k]),
      .valid_o(d_valid[k+1]),
      .ready_i(d_ready[k+1]),
      .rem_o  (d_rem[k+1]),
      .quo_o  (d_quo[k+1]),
      .den_o  (d_den[k+1]),
      .alpha_o(d_alpha[k+1]),
      .zero_o (d_zero[k+1])
    );
  end

  assign d_ready[COLOR_BITS] = !out_valid_q || out_ready_i;
  assign out_load            = d_valid[COLOR_BITS] && d_ready[COLOR_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (d_ready[COLOR_BITS]) begin
      out_valid_q <= d_valid[COLOR_BITS];
    end
  end

  // With both alphas zero the divider output is meaningless and is dropped.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      color_q <= d_zero[COLOR_BITS] ? '0 : d_quo[COLOR_BITS];
      alpha_q <= d_zero[COLOR_BITS] ? '0 : d_alpha[COLOR_BITS];
      zero_q  <= d_zero[COLOR_BITS];
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_red_o          = color_q[0];
  assign out_green_o        = color_q[1];
  assign out_blue_o         = color_q[2];
  assign out_alpha_o        = alpha_q;
  assign both_transparent_o = zero_q;

endmodule
